/* hw/rtl/gwm_pkg.sv */
package gwm_pkg;

   // Default sizes, handed down from the top level
   localparam int PATTERN_DEPTH_DEF    = 64;
   localparam int SUBJECT_LEN_BITS_DEF = 16;

   // Wildcard characters
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;

   // Request selector (tuser bit 0)
   localparam logic FUNC_PATTERN = 1'b0;
   localparam logic FUNC_SUBJECT = 1'b1;

   // Result kind (rsp tuser)
   localparam logic KIND_CLASS = 1'b0;
   localparam logic KIND_MATCH = 1'b1;

   typedef enum logic [2:0] {
      CLS_DEAD    = 3'd0,
      CLS_LITERAL = 3'd1,
      CLS_WILD    = 3'd2,
      CLS_PREFIX  = 3'd3,
      CLS_SUFFIX  = 3'd4,
      CLS_MIXED   = 3'd5
   } class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } walk_state_type;

   // Pattern side status seen by the subject matcher
   typedef struct packed {
      logic      pat_open;
      logic      has_star;
      class_type pattern_class;
   } pat_status_type;

   // One result, valid for a single cycle
   typedef struct packed {
      logic      valid;
      logic      kind;
      class_type pattern_class;
      logic      matched;
   } result_type;

   function automatic logic is_wild(input logic [7:0] b);
      return (b == CHAR_STAR) || (b == CHAR_QMARK);
   endfunction

endpackage

/* hw/rtl/single_wildcard_glob_match_unit.sv */
// Glob matcher for patterns with at most one wildcard ('*' or '?').
// Request channel (req_*): one byte per request. tuser bit 0 selects a
// pattern byte (0) or a subject byte (1); tuser bit 1 marks a request that
// carries no byte, used to close an empty pattern or subject; tlast closes
// the pattern or subject. A pattern ends in a class response (tuser 0),
// a subject ends in a match response (tuser 1); other requests give none.
// Response channel (rsp_*): tdata holds the class code in bits 2:0 and the
// match flag in bit 3.
// Throughput: one request per cycle while req_tready is high. A response
// appears in the cycle after the closing request, except for a subject
// against a suffix or mixed pattern that passes the length and prefix
// checks: the suffix is walked one byte a cycle through the pattern store
// and tail ring read ports, the response comes out of the drain state after
// the walk, and req_tready is low through the walk and drain states.
// req_tready also drops while a response waits and rsp_tready is low.
// Reset clears all counters and classes the pattern as dead; the pattern
// store and tail ring need no clearing.
module single_wildcard_glob_match_unit
   import gwm_pkg::*;
#(
   parameter int PATTERN_DEPTH    = PATTERN_DEPTH_DEF,
   parameter int SUBJECT_LEN_BITS = SUBJECT_LEN_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic [1:0] req_tuser,   // [0] func, [1] no_byte
   input  logic       req_tlast,   // last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] pattern_class, [3] matched, [7:4] zero
   output logic       rsp_tuser    // [0] kind
);

   localparam int AW = $clog2(PATTERN_DEPTH);
   localparam int LW = $clog2(PATTERN_DEPTH + 1);

   logic           accept, pat_item, subj_item, has_byte, subj_idle;
   logic           pw_en, pat_start;
   logic [AW-1:0]  pw_addr, pat_rd_addr;
   logic [7:0]     pw_data, pat_rd_data;
   logic           ring_wr_en;
   logic [AW-1:0]  ring_wr_addr, ring_rd_addr;
   logic [7:0]     ring_wr_data, ring_rd_data;
   pat_status_type status;
   logic [LW-1:0]  pat_len, min_len, prefix_len, suffix_len;
   result_type     pat_res, subj_res;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           kind_ff;
   class_type      class_ff;
   logic           matched_ff;

   // Request handshake
   assign req_tready = subj_idle && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign pat_item   = accept && (req_tuser[0] == FUNC_PATTERN);
   assign subj_item  = accept && (req_tuser[0] == FUNC_SUBJECT);
   assign has_byte   = !req_tuser[1];

   gwm_pat_ctl #(
      .PATTERN_DEPTH(PATTERN_DEPTH)
   ) u_pat_ctl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pat_item),
      .byte_value (req_tdata),
      .has_byte   (has_byte),
      .last       (req_tlast),
      .wr_en      (pw_en),
      .wr_addr    (pw_addr),
      .wr_data    (pw_data),
      .pat_start  (pat_start),
      .status     (status),
      .pat_len    (pat_len),
      .min_len    (min_len),
      .prefix_len (prefix_len),
      .suffix_len (suffix_len),
      .result     (pat_res)
   );

   gwm_ram #(
      .WIDTH(8),
      .DEPTH(PATTERN_DEPTH)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pw_en),
      .wr_addr (pw_addr),
      .wr_data (pw_data),
      .rd_addr (pat_rd_addr),
      .rd_data (pat_rd_data)
   );

   gwm_ram #(
      .WIDTH(8),
      .DEPTH(PATTERN_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   gwm_subj_ctl #(
      .PATTERN_DEPTH    (PATTERN_DEPTH),
      .SUBJECT_LEN_BITS (SUBJECT_LEN_BITS)
   ) u_subj_ctl (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (subj_item),
      .byte_value   (req_tdata),
      .has_byte     (has_byte),
      .last         (req_tlast),
      .pat_start    (pat_start),
      .status       (status),
      .pat_len      (pat_len),
      .min_len      (min_len),
      .prefix_len   (prefix_len),
      .suffix_len   (suffix_len),
      .pw_en        (pw_en),
      .pw_addr      (pw_addr),
      .pw_data      (pw_data),
      .pat_rd_addr  (pat_rd_addr),
      .pat_rd_data  (pat_rd_data),
      .ring_wr_en   (ring_wr_en),
      .ring_wr_addr (ring_wr_addr),
      .ring_wr_data (ring_wr_data),
      .ring_rd_addr (ring_rd_addr),
      .ring_rd_data (ring_rd_data),
      .idle         (subj_idle),
      .result       (subj_res)
   );

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (pat_res.valid || subj_res.valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pat_res.valid) begin
         kind_ff    <= pat_res.kind;
         class_ff   <= pat_res.pattern_class;
         matched_ff <= pat_res.matched;
      end else if (subj_res.valid) begin
         kind_ff    <= subj_res.kind;
         class_ff   <= subj_res.pattern_class;
         matched_ff <= subj_res.matched;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, matched_ff, class_ff};
   assign rsp_tuser  = kind_ff;

endmodule

/* hw/rtl/gwm_ram.sv */
module gwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port (old data on a collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/gwm_pat_ctl.sv */
module gwm_pat_ctl
   import gwm_pkg::*;
#(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
   localparam int AW = $clog2(PATTERN_DEPTH),
   localparam int LW = $clog2(PATTERN_DEPTH + 1)
) (
   input  logic           clock,
   input  logic           reset,
   // accepted pattern request
   input  logic           item_valid,
   input  logic [7:0]     byte_value,
   input  logic           has_byte,
   input  logic           last,
   // pattern store write port
   output logic           wr_en,
   output logic [AW-1:0]  wr_addr,
   output logic [7:0]     wr_data,
   // status toward the subject side
   output logic           pat_start,
   output pat_status_type status,
   output logic [LW-1:0]  pat_len,
   output logic [LW-1:0]  min_len,
   output logic [LW-1:0]  prefix_len,
   output logic [LW-1:0]  suffix_len,
   output result_type     result
);

   logic [LW-1:0] len_ff,    len_in;
   logic [LW-1:0] wc_ff,     wc_in;
   logic [LW-1:0] prefix_ff, prefix_in;
   logic [LW-1:0] suffix_ff, suffix_in;
   logic [LW-1:0] min_ff,    min_in;
   logic          star_ff,   star_in;
   logic          ovf_ff,    ovf_in;
   logic          open_ff,   open_in;
   logic          first_wild_ff, first_wild_in;
   logic          last_wild_ff,  last_wild_in;
   class_type     class_ff,  class_in;
   logic          wild;

   assign wild = is_wild(byte_value);

   // Counter update, store write and classification at the end of a pattern
   always_comb begin
      len_in        = len_ff;
      wc_in         = wc_ff;
      prefix_in     = prefix_ff;
      suffix_in     = suffix_ff;
      min_in        = min_ff;
      star_in       = star_ff;
      ovf_in        = ovf_ff;
      open_in       = open_ff;
      first_wild_in = first_wild_ff;
      last_wild_in  = last_wild_ff;
      class_in      = class_ff;
      wr_en         = 1'b0;
      wr_addr       = len_ff[AW-1:0];
      if (item_valid) begin
         // first request of a pattern starts from a clean slate
         if (!open_ff) begin
            len_in    = '0;
            wc_in     = '0;
            prefix_in = '0;
            suffix_in = '0;
            min_in    = '0;
            star_in   = 1'b0;
            ovf_in    = 1'b0;
            class_in  = CLS_DEAD;
         end
         open_in = 1'b1;
         if (has_byte) begin
            if (len_in == LW'(PATTERN_DEPTH)) begin
               ovf_in = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = len_in[AW-1:0];
               if (len_in == '0) begin
                  first_wild_in = wild;
               end
               last_wild_in = wild;
               len_in       = len_in + LW'(1);
               if (wild) begin
                  wc_in     = wc_in + LW'(1);
                  suffix_in = '0;
               end else if (wc_in == '0) begin
                  prefix_in = prefix_in + LW'(1);
               end else begin
                  suffix_in = suffix_in + LW'(1);
               end
               if (byte_value == CHAR_STAR) begin
                  star_in = 1'b1;
               end else begin
                  min_in = min_in + LW'(1);
               end
            end
         end
         if (last) begin
            open_in = 1'b0;
            if (ovf_in) begin
               class_in = CLS_DEAD;
            end else if (len_in == wc_in) begin
               class_in = CLS_WILD;
            end else if (wc_in == '0) begin
               class_in = CLS_LITERAL;
            end else if (wc_in == LW'(1)) begin
               if (first_wild_in) begin
                  class_in = CLS_SUFFIX;
               end else if (last_wild_in) begin
                  class_in = CLS_PREFIX;
               end else begin
                  class_in = CLS_MIXED;
               end
            end else begin
               class_in = CLS_DEAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         wc_ff         <= '0;
         prefix_ff     <= '0;
         suffix_ff     <= '0;
         min_ff        <= '0;
         star_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
         open_ff       <= 1'b0;
         first_wild_ff <= 1'b0;
         last_wild_ff  <= 1'b0;
         class_ff      <= CLS_DEAD;
      end else begin
         len_ff        <= len_in;
         wc_ff         <= wc_in;
         prefix_ff     <= prefix_in;
         suffix_ff     <= suffix_in;
         min_ff        <= min_in;
         star_ff       <= star_in;
         ovf_ff        <= ovf_in;
         open_ff       <= open_in;
         first_wild_ff <= first_wild_in;
         last_wild_ff  <= last_wild_in;
         class_ff      <= class_in;
      end
   end

   assign wr_data   = byte_value;
   assign pat_start = item_valid && !open_ff;

   assign status.pat_open      = open_ff;
   assign status.has_star      = star_ff;
   assign status.pattern_class = class_ff;
   assign pat_len    = len_ff;
   assign min_len    = min_ff;
   assign prefix_len = prefix_ff;
   assign suffix_len = suffix_ff;

   // Classification result goes out with the last pattern request
   assign result.valid         = item_valid && last;
   assign result.kind          = KIND_CLASS;
   assign result.pattern_class = class_in;
   assign result.matched       = 1'b0;

`ifndef SYNTHESIS
   a_wild_le_len: assert property (@(posedge clock) disable iff (reset)
      wc_ff <= len_ff)
      else $error("wildcard count exceeds pattern length");
   a_parts_le_len: assert property (@(posedge clock) disable iff (reset)
      ((LW+2)'(prefix_ff) + (LW+2)'(suffix_ff) + (LW+2)'(wc_ff)) <= (LW+2)'(len_ff))
      else $error("prefix, suffix and wildcards exceed pattern length");
   a_close_on_last: assert property (@(posedge clock) disable iff (reset)
      item_valid && last |=> !open_ff && (class_ff == $past(class_in)))
      else $error("pattern not closed after its last request");
`endif

endmodule

/* hw/rtl/gwm_subj_ctl.sv */
module gwm_subj_ctl
   import gwm_pkg::*;
#(
   parameter int PATTERN_DEPTH    = PATTERN_DEPTH_DEF,
   parameter int SUBJECT_LEN_BITS = SUBJECT_LEN_BITS_DEF,
   localparam int AW = $clog2(PATTERN_DEPTH),
   localparam int LW = $clog2(PATTERN_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   // accepted subject request
   input  logic                        item_valid,
   input  logic [7:0]                  byte_value,
   input  logic                        has_byte,
   input  logic                        last,
   // pattern side
   input  logic                        pat_start,
   input  pat_status_type              status,
   input  logic [LW-1:0]               pat_len,
   input  logic [LW-1:0]               min_len,
   input  logic [LW-1:0]               prefix_len,
   input  logic [LW-1:0]               suffix_len,
   input  logic                        pw_en,
   input  logic [AW-1:0]               pw_addr,
   input  logic [7:0]                  pw_data,
   // pattern store read port
   output logic [AW-1:0]               pat_rd_addr,
   input  logic [7:0]                  pat_rd_data,
   // tail ring ports
   output logic                        ring_wr_en,
   output logic [AW-1:0]               ring_wr_addr,
   output logic [7:0]                  ring_wr_data,
   output logic [AW-1:0]               ring_rd_addr,
   input  logic [7:0]                  ring_rd_data,
   // control
   output logic                        idle,
   output result_type                  result
);

   localparam int CW = (SUBJECT_LEN_BITS > LW) ? SUBJECT_LEN_BITS : LW;

   walk_state_type              state_ff, state_in;
   logic [SUBJECT_LEN_BITS-1:0] len_ff, len_in, len_new;
   logic [AW-1:0]               rp_ff, rp_in, rp_new;
   logic                        pok_ff, pok_in, pok_new;
   logic [LW-1:0]               walk_left_ff, walk_left_in;
   logic [AW-1:0]               walk_pat_ff, walk_pat_in;
   logic [AW-1:0]               walk_ring_ff, walk_ring_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic                        mismatch_ff, mismatch_in;
   logic [AW-1:0]               rd_addr_ff;
   logic                        fwd_hit_ff, fwd_hit_in;
   logic [7:0]                  fwd_data_ff;
   logic [7:0]                  pat_data;
   logic [CW-1:0]               len_x, len_new_x, len_next_x;
   logic                        len_ok, base_ok, go_walk, cmp_miss;
   logic [LW:0]                 ring_start;

   // Prefetched pattern byte, with forwarding of a same-cycle store write
   assign pat_data = fwd_hit_ff ? fwd_data_ff : pat_rd_data;
   assign cmp_miss = cmp_valid_ff && (pat_data != ring_rd_data);
   assign len_x    = CW'(len_ff);

   // Subject counters, prefix compare, judgement and walk setup
   always_comb begin
      len_new      = len_ff;
      rp_new       = rp_ff;
      pok_new      = pok_ff;
      ring_wr_en   = 1'b0;
      len_ok       = 1'b0;
      base_ok      = 1'b0;
      go_walk      = 1'b0;
      walk_left_in = walk_left_ff;
      walk_pat_in  = walk_pat_ff;
      walk_ring_in = walk_ring_ff;
      mismatch_in  = mismatch_ff | cmp_miss;
      ring_start   = '0;
      if (item_valid && has_byte) begin
         if (!(&len_ff)) begin
            if (len_x < CW'(prefix_len) && pat_data != byte_value) begin
               pok_new = 1'b0;
            end
            len_new = len_ff + SUBJECT_LEN_BITS'(1);
         end
         ring_wr_en = 1'b1;
         rp_new = (rp_ff == AW'(PATTERN_DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      end
      len_new_x = CW'(len_new);
      len_ok = !(len_new_x < CW'(min_len)) &&
               (status.has_star || len_new_x == CW'(pat_len));
      case (status.pattern_class) inside
         CLS_WILD:                base_ok = len_ok;
         CLS_LITERAL, CLS_PREFIX: base_ok = len_ok && pok_new;
         CLS_SUFFIX:              base_ok = len_ok;
         CLS_MIXED:               base_ok = len_ok && pok_new;
         default:                 base_ok = 1'b0;
      endcase
      if (status.pat_open) begin
         base_ok = 1'b0;
      end
      go_walk = item_valid && last && base_ok && suffix_len != '0 &&
                (status.pattern_class == CLS_SUFFIX || status.pattern_class == CLS_MIXED);
      // start of the suffix inside the ring and inside the pattern store
      ring_start = (LW+1)'(rp_new) + (LW+1)'(PATTERN_DEPTH) - (LW+1)'(suffix_len);
      if (ring_start >= (LW+1)'(PATTERN_DEPTH)) begin
         ring_start = ring_start - (LW+1)'(PATTERN_DEPTH);
      end
      if (go_walk) begin
         walk_left_in = suffix_len;
         walk_pat_in  = AW'(pat_len - suffix_len);
         walk_ring_in = ring_start[AW-1:0];
         mismatch_in  = 1'b0;
      end else if (state_ff == ST_WALK) begin
         walk_left_in = walk_left_ff - LW'(1);
         walk_pat_in  = walk_pat_ff + AW'(1);
         walk_ring_in = (walk_ring_ff == AW'(PATTERN_DEPTH - 1)) ? '0
                                                                 : walk_ring_ff + AW'(1);
      end
      // a new pattern or the end of a subject clears the subject
      if (pat_start || (item_valid && last)) begin
         len_in = '0;
         rp_in  = '0;
         pok_in = 1'b1;
      end else begin
         len_in = len_new;
         rp_in  = rp_new;
         pok_in = pok_new;
      end
      cmp_valid_in = (state_ff == ST_WALK);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (go_walk) state_in = ST_WALK;
         ST_WALK:  if (walk_left_ff == LW'(1)) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs: read addresses and results
   always_comb begin
      len_next_x   = CW'(len_in);
      pat_rd_addr  = len_next_x[AW-1:0];
      ring_rd_addr = walk_ring_ff;
      idle         = 1'b0;
      result.valid         = 1'b0;
      result.kind          = KIND_MATCH;
      result.pattern_class = status.pattern_class;
      result.matched       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idle           = 1'b1;
            result.valid   = item_valid && last && !go_walk;
            result.matched = base_ok;
         end
         ST_WALK: begin
            pat_rd_addr = walk_pat_ff;
         end
         ST_DRAIN: begin
            result.valid   = 1'b1;
            result.matched = !(mismatch_ff || cmp_miss);
         end
         default: begin
            idle = 1'b0;
         end
      endcase
      fwd_hit_in = pw_en && (pw_addr == pat_rd_addr);
   end

   assign ring_wr_addr = rp_ff;
   assign ring_wr_data = byte_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rp_ff        <= '0;
         pok_ff       <= 1'b1;
         walk_left_ff <= '0;
         cmp_valid_ff <= 1'b0;
         mismatch_ff  <= 1'b0;
         rd_addr_ff   <= '0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rp_ff        <= rp_in;
         pok_ff       <= pok_in;
         walk_left_ff <= walk_left_in;
         cmp_valid_ff <= cmp_valid_in;
         mismatch_ff  <= mismatch_in;
         rd_addr_ff   <= pat_rd_addr;
         fwd_hit_ff   <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_pat_ff  <= walk_pat_in;
      walk_ring_ff <= walk_ring_in;
      fwd_data_ff  <= pw_data;
   end

`ifndef SYNTHESIS
   a_prefetch_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> rd_addr_ff == len_x[AW-1:0])
      else $error("prefetched pattern byte does not match subject position");
   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> walk_left_ff != '0)
      else $error("suffix walk with nothing left to compare");
   a_no_item_in_walk: assert property (@(posedge clock) disable iff (reset)
      (pat_start || item_valid) |-> state_ff == ST_IDLE)
      else $error("request taken while the suffix walk runs");
`endif

endmodule

/* sim/tb.sv */
module tb;
   import gwm_pkg::*;

   localparam int DEPTH       = PATTERN_DEPTH_DEF;
   localparam int LEN_MAX     = (1 << SUBJECT_LEN_BITS_DEF) - 1;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASE_ITEMS = 250;

   typedef logic [7:0] byte_q_type[$];

   typedef struct {
      logic      kind;
      class_type cls;
      logic      matched;
   } match_rsp_type;

   // Predicts class and match responses and checks what the block returns
   class glob_match_scoreboard;
      logic [7:0]    pat_mem[DEPTH];
      logic [7:0]    tail_ring[DEPTH];
      int            pat_len, wild_cnt, pfx_len, sfx_len, min_len;
      int            ring_ptr, subj_len;
      logic          has_star, overflow, pfx_ok, pat_open;
      class_type     cls;
      match_rsp_type expected_rsp[$];
      int            errors;

      function new();
         clear_pattern();
         clear_subject();
         pat_open = 1'b0;
         errors   = 0;
      endfunction

      function void clear_pattern();
         pat_len  = 0;
         wild_cnt = 0;
         pfx_len  = 0;
         sfx_len  = 0;
         min_len  = 0;
         has_star = 1'b0;
         overflow = 1'b0;
         cls      = CLS_DEAD;
      endfunction

      function void clear_subject();
         subj_len = 0;
         ring_ptr = 0;
         pfx_ok   = 1'b1;
      endfunction

      function logic is_wild_byte(logic [7:0] b);
         return b == CHAR_STAR || b == CHAR_QMARK;
      endfunction

      function class_type classify_pattern();
         if (overflow) return CLS_DEAD;
         if (pat_len == wild_cnt) return CLS_WILD;
         if (wild_cnt == 0) return CLS_LITERAL;
         if (wild_cnt == 1) begin
            if (is_wild_byte(pat_mem[0])) return CLS_SUFFIX;
            if (is_wild_byte(pat_mem[pat_len - 1])) return CLS_PREFIX;
            return CLS_MIXED;
         end
         return CLS_DEAD;
      endfunction

      // last sfx_len subject bytes against the pattern tail
      function logic suffix_matches();
         int r;
         if (sfx_len > pat_len) return 1'b0;
         for (int i = 0; i < sfx_len; i++) begin
            r = (ring_ptr + DEPTH - sfx_len + i) % DEPTH;
            if (tail_ring[r] != pat_mem[pat_len - sfx_len + i]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function logic subject_matches();
         if (pat_open) return 1'b0;
         if (subj_len < min_len || (!has_star && subj_len != pat_len)) return 1'b0;
         case (cls) inside
            CLS_WILD:                return 1'b1;
            CLS_LITERAL, CLS_PREFIX: return pfx_ok;
            CLS_SUFFIX:              return suffix_matches();
            CLS_MIXED:               return pfx_ok && suffix_matches();
            default:                 return 1'b0;
         endcase
      endfunction

      // accepted request: update state, queue a response on tlast
      function void note_request(logic func, logic [7:0] b, logic no_byte, logic last);
         match_rsp_type rsp;
         if (func == FUNC_PATTERN) begin
            if (!pat_open) begin
               clear_pattern();
               clear_subject();
               pat_open = 1'b1;
            end
            if (!no_byte) begin
               if (pat_len >= DEPTH) begin
                  overflow = 1'b1;
               end else begin
                  pat_mem[pat_len] = b;
                  pat_len++;
                  if (is_wild_byte(b)) begin
                     wild_cnt++;
                     sfx_len = 0;
                  end else if (wild_cnt == 0) begin
                     pfx_len++;
                  end else begin
                     sfx_len++;
                  end
                  if (b == CHAR_STAR) has_star = 1'b1;
                  else min_len++;
               end
            end
            if (last) begin
               cls         = classify_pattern();
               pat_open    = 1'b0;
               rsp.kind    = KIND_CLASS;
               rsp.cls     = cls;
               rsp.matched = 1'b0;
               expected_rsp.push_back(rsp);
            end
         end else begin
            if (!no_byte) begin
               // length saturates; prefix compare stops with it
               if (subj_len < LEN_MAX) begin
                  if (subj_len < pfx_len && pat_mem[subj_len] != b) pfx_ok = 1'b0;
                  subj_len++;
               end
               tail_ring[ring_ptr] = b;
               ring_ptr = (ring_ptr + 1) % DEPTH;
            end
            if (last) begin
               rsp.kind    = KIND_MATCH;
               rsp.cls     = cls;
               rsp.matched = subject_matches();
               expected_rsp.push_back(rsp);
               clear_subject();
            end
         end
      endfunction

      function void flag(string what, logic kind, logic [7:0] data, match_rsp_type exp);
         if (errors < 10)
            $display("%s: got kind %0d data %02h, expected kind %0d class %0d matched %0d",
                     what, kind, data, exp.kind, exp.cls, exp.matched);
         errors++;
      endfunction

      function void check_response(logic kind, logic [7:0] data);
         match_rsp_type exp;
         if (expected_rsp.size() == 0) begin
            exp.kind    = 1'bx;
            exp.cls     = CLS_DEAD;
            exp.matched = 1'bx;
            flag("unexpected response", kind, data, exp);
            return;
         end
         exp = expected_rsp.pop_front();
         if (kind !== exp.kind || data[2:0] !== exp.cls || data[3] !== exp.matched ||
             data[7:4] !== 4'b0)
            flag("response mismatch", kind, data, exp);
      endfunction
   endclass

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] byte_value
   logic [1:0] req_tuser  = 2'b00;  // [0] func, [1] no_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [2:0] pattern_class, [3] matched, [7:4] zero
   logic       rsp_tuser;           // [0] kind

   glob_match_scoreboard sb = new();
   int gap_pct     = 0;
   int stall_pct   = 0;
   int items_sent  = 0;
   int quiet_cycles = 0;

   single_wildcard_glob_match_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // handshake monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tuser[0], req_tdata, req_tuser[1], req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [7:0] lit_byte();
      logic [7:0] b;
      if ($urandom_range(3) != 0) return 8'h61 + 8'($urandom_range(3));
      do b = 8'($urandom); while (b == CHAR_STAR || b == CHAR_QMARK);
      return b;
   endfunction

   function automatic int lit_len();
      return ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(5);
   endfunction

   function automatic byte_q_type make_pattern();
      byte_q_type p;
      int         sel;
      logic [7:0] w;
      sel = $urandom_range(99);
      w   = $urandom_range(1) ? CHAR_STAR : CHAR_QMARK;
      repeat (lit_len()) p.push_back(lit_byte());
      if (sel < 10) begin
         // literal only
      end else if (sel < 25) begin
         p.push_back(w);
      end else if (sel < 40) begin
         p.delete();
         p.push_back(w);
         repeat (lit_len()) p.push_back(lit_byte());
      end else if (sel < 70) begin
         p.push_back(w);
         repeat (lit_len()) p.push_back(lit_byte());
      end else if (sel < 78) begin
         p.delete();
         if ($urandom_range(2) != 0) p.push_back(w);
      end else if (sel < 90) begin
         // two wildcards: dead
         p.push_back(w);
         repeat (lit_len()) p.push_back(lit_byte());
         p.insert($urandom_range(p.size()), $urandom_range(1) ? CHAR_STAR : CHAR_QMARK);
      end else if (sel < 95) begin
         // around the store depth, mostly overflowing
         p.delete();
         repeat (DEPTH + $urandom_range(6))
            p.push_back(($urandom_range(15) == 0) ? w : lit_byte());
      end else begin
         p.delete();
         repeat (1 + $urandom_range(7)) p.push_back(8'($urandom));
      end
      return p;
   endfunction

   // mostly a matching expansion of the pattern, sometimes damaged
   function automatic byte_q_type make_subject(input byte_q_type pat);
      byte_q_type s;
      int         n;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(10)) s.push_back(lit_byte());
         return s;
      end
      foreach (pat[i]) begin
         if (pat[i] == CHAR_STAR) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(120) : $urandom_range(4);
            repeat (n) s.push_back(lit_byte());
         end else if (pat[i] == CHAR_QMARK) begin
            s.push_back(8'($urandom));
         end else begin
            s.push_back(pat[i]);
         end
      end
      if ($urandom_range(3) == 0 && s.size() > 0) begin
         n = $urandom_range(s.size() - 1);
         case ($urandom_range(2))
            0:       s[n] = s[n] ^ (8'h01 << $urandom_range(7));
            1:       s.delete(n);
            default: s.push_back(lit_byte());
         endcase
      end
      return s;
   endfunction

   task automatic send_req(input logic func, input logic [7:0] b, input logic no_byte,
                           input logic last);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {no_byte, func};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // one pattern or subject, with occasional byte-less requests mixed in
   task automatic send_seq(input logic func, input byte_q_type seq);
      logic split_end;
      split_end = (seq.size() == 0) || ($urandom_range(9) == 0);
      foreach (seq[i]) begin
         if ($urandom_range(24) == 0) send_req(func, 8'($urandom), 1'b1, 1'b0);
         send_req(func, seq[i], 1'b0, !split_end && i == seq.size() - 1);
      end
      if (split_end) send_req(func, 8'($urandom), 1'b1, 1'b1);
   endtask

   // drop req_tvalid and let the monitor note the final request before polling
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      byte_q_type p, s;
      int         phase_end;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: subject before any pattern, empty pattern and subject
      s = {8'h78};
      send_seq(FUNC_SUBJECT, s);
      p.delete();
      send_seq(FUNC_PATTERN, p);
      s.delete();
      send_seq(FUNC_SUBJECT, s);
      // literal with extreme byte values
      p = {8'h00, 8'hFF};
      send_seq(FUNC_PATTERN, p);
      send_seq(FUNC_SUBJECT, p);
      s = {8'h00, 8'hFE};
      send_seq(FUNC_SUBJECT, s);
      // prefix, suffix, mixed and a two-wildcard pattern
      p = {8'h61, CHAR_STAR};
      send_seq(FUNC_PATTERN, p);
      s = {8'h61, 8'h62, 8'h63};
      send_seq(FUNC_SUBJECT, s);
      p = {CHAR_QMARK, 8'h7A};
      send_seq(FUNC_PATTERN, p);
      s = {8'h71, 8'h7A};
      send_seq(FUNC_SUBJECT, s);
      p = {8'h61, CHAR_STAR, 8'h7A};
      send_seq(FUNC_PATTERN, p);
      s = {8'h61, 8'h7A};
      send_seq(FUNC_SUBJECT, s);
      p = {CHAR_STAR, CHAR_QMARK};
      send_seq(FUNC_PATTERN, p);
      s = {8'h78};
      send_seq(FUNC_SUBJECT, s);
      // subject arriving while a pattern is still open
      send_req(FUNC_PATTERN, 8'h61, 1'b0, 1'b0);
      send_req(FUNC_SUBJECT, 8'h61, 1'b0, 1'b1);
      send_req(FUNC_PATTERN, 8'h62, 1'b0, 1'b1);
      wait_drained();

      // full-depth literal, then a subject that wraps the tail ring
      p.delete();
      repeat (DEPTH) p.push_back(lit_byte());
      send_seq(FUNC_PATTERN, p);
      send_seq(FUNC_SUBJECT, p);
      p = {8'h61, 8'h62, CHAR_STAR, 8'h79, 8'h7A};
      send_seq(FUNC_PATTERN, p);
      s = {8'h61, 8'h62};
      repeat (DEPTH + 37) s.push_back(8'($urandom));
      s.push_back(8'h79);
      s.push_back(8'h7A);
      send_seq(FUNC_SUBJECT, s);
      wait_drained();
      items_sent = 0;

      // random phases with different idling on each side
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 81; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 81; end
            default: begin gap_pct = 12; stall_pct = 12; end
         endcase
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            // broken sequence: open pattern interrupted by a subject
            if ($urandom_range(24) == 0) begin
               repeat (1 + $urandom_range(2)) send_req(FUNC_PATTERN, lit_byte(), 1'b0, 1'b0);
               send_seq(FUNC_SUBJECT, make_subject(p));
            end
            p = make_pattern();
            send_seq(FUNC_PATTERN, p);
            repeat (1 + $urandom_range(4)) send_seq(FUNC_SUBJECT, make_subject(p));
         end
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_ram.sv
hw/rtl/gwm_pat_ctl.sv
hw/rtl/gwm_subj_ctl.sv
hw/rtl/single_wildcard_glob_match_unit.sv
sim/tb.sv
